@@ src/ecv_pkg.sv @@
// Shared types, constants and calendar helpers for the epoch/DOS/NT time converter.
package ecv_pkg;

	localparam int unsigned NumStages = 10;

	typedef enum logic [2:0] {
		OP_TO_DOS     = 3'd0,
		OP_FROM_DOS   = 3'd1,
		OP_TO_NT      = 3'd2,
		OP_FROM_NT    = 3'd3,
		OP_TO_LOCAL   = 3'd4,
		OP_FROM_LOCAL = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic [31:0]        seconds_in;
		logic [15:0]        dos_date_in;
		logic [15:0]        dos_time_in;
		logic signed [63:0] nt_time_in;
	} in_t;

	typedef struct packed {
		logic [31:0] seconds_out;
		logic [15:0] dos_date_out;
		logic [15:0] dos_time_out;
		logic [57:0] nt_time_out;
		logic        range_error;
	} out_t;

	// seconds from 1601-01-01 to 1970-01-01
	localparam logic [63:0] NtEpochGap = 64'd11644473600;
	localparam logic [23:0] NtTicks    = 24'd10000000;
	// 10^7 = 2^7 * 78125; floor(x / 78125) = (x * NtRcp) >> 74, exact for x < 2^57
	localparam logic [57:0] NtRcp      = 58'((128'd1 << 81) / 128'd10000000 + 128'd1);
	localparam logic [28:0] NtRcpLo    = NtRcp[28:0];
	localparam logic [28:0] NtRcpHi    = NtRcp[57:29];

	// 86400 = 2^7 * 675; floor(2^35 / 675), one correction step after
	localparam logic [9:0]  Div675     = 10'd675;
	localparam logic [25:0] Rcp675     = 26'd50903316;
	// exact reciprocals over the value ranges used
	localparam logic [16:0] Rcp225     = 17'd74566;   // 2^24
	localparam logic [12:0] Rcp15      = 13'd4370;    // 2^16
	localparam logic [15:0] Rcp1461    = 16'd45934;   // 2^26
	localparam logic [10:0] Days4Yr    = 11'd1461;

	// days 1968-01-01 to 1970-01-01, and day index of 2100-03-01 from 1968
	localparam logic [16:0] DaysFrom1968 = 17'd731;
	localparam logic [16:0] Skip2100     = 17'd48272;

	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		if (leap && (m inside {[4'd2:4'd11]}))
			d = d + 9'd1;
		return d;
	endfunction

endpackage

@@ src/epoch_dos_nt_time_converter.sv @@
// Top level of the epoch / FAT date-time / NT file time converter.
// Takes one transfer per clock while in_stall is low and returns one result
// per transfer, in order. The pipeline depth is set by the epoch-to-FAT path:
// day split by reciprocal multiply, then year, month and time-of-day fields,
// ten stages in all; the other paths are padded to match. Stalls propagate
// stage by stage, so bubbles close up and input is refused only when all ten
// stages hold data.
// zone_offset is sampled by items in flight; write it only while idle.
module epoch_dos_nt_time_converter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ecv_pkg::in_t         in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ecv_pkg::out_t        out_data,
	input  logic                 cfg_wen,
	input  logic signed [17:0]   cfg_wdata
);

	localparam int unsigned NS = ecv_pkg::NumStages;

	logic signed [17:0] off_q;
	logic [NS-1:0]      valid_q;
	logic [NS:0]        rdy;
	logic [NS-1:0]      en;

	logic [15:0] dd_date, dd_time;
	logic        dd_err, sc_err;
	logic [31:0] sc_secs, nt_secs;
	logic [57:0] nt_val;

	always_comb begin
		rdy[NS] = !out_stall;
		for (int k = NS - 1; k >= 0; k--)
			rdy[k] = !valid_q[k] || rdy[k+1];
	end

	assign en        = rdy[NS-1:0];
	assign in_stall  = !rdy[0];
	assign out_valid = valid_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0])
				valid_q[0] <= in_valid;
			for (int k = 1; k < NS; k++)
				if (en[k])
					valid_q[k] <= valid_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (cfg_wen) begin
			off_q <= cfg_wdata;
		end
	end

	ecv_to_dos u_to_dos (
		.clk         (clk),
		.en          (en),
		.operation   (in_data.operation),
		.seconds_in  (in_data.seconds_in),
		.zone_offset (off_q),
		.dos_date    (dd_date),
		.dos_time    (dd_time),
		.range_error (dd_err)
	);

	ecv_secs u_secs (
		.clk         (clk),
		.en          (en),
		.operation   (in_data.operation),
		.seconds_in  (in_data.seconds_in),
		.dos_date_in (in_data.dos_date_in),
		.dos_time_in (in_data.dos_time_in),
		.zone_offset (off_q),
		.seconds     (sc_secs),
		.range_error (sc_err)
	);

	ecv_nt u_nt (
		.clk        (clk),
		.en         (en),
		.operation  (in_data.operation),
		.seconds_in (in_data.seconds_in),
		.nt_time_in (in_data.nt_time_in),
		.nt_time    (nt_val),
		.seconds    (nt_secs)
	);

	always_comb begin
		out_data.seconds_out  = sc_secs | nt_secs;
		out_data.dos_date_out = dd_date;
		out_data.dos_time_out = dd_time;
		out_data.nt_time_out  = nt_val;
		out_data.range_error  = dd_err | sc_err;
	end

endmodule

@@ src/ecv_to_dos.sv @@
// Epoch seconds plus zone offset to packed FAT date and time, ten stages.
module ecv_to_dos (
	input  logic                               clk,
	input  logic [ecv_pkg::NumStages-1:0]      en,
	input  logic [2:0]                         operation,
	input  logic [31:0]                        seconds_in,
	input  logic signed [17:0]                 zone_offset,
	output logic [15:0]                        dos_date,
	output logic [15:0]                        dos_time,
	output logic                               range_error
);

	logic [ecv_pkg::NumStages-1:1] sel_s;

	logic [31:0] t_s1, t_s2, t_s3;
	logic [50:0] p_s2;
	logic [15:0] q_s3;
	logic [25:0] pq_s3;
	logic [15:0] days_s4;
	logic [16:0] rem_s4, rem_s5, rem_s6;
	logic [15:0] dp_s5, dp_s6, dp_s7;
	logic [29:0] hp_s5;
	logic [31:0] cp_s6;
	logic [4:0]  hour_s6, hour_s7, hour_s8, hour_s9;
	logic [16:0] hm_s6;
	logic [5:0]  c_s7, c_s8;
	logic [15:0] cm_s7;
	logic [11:0] rem2_s7, rem2_s8;
	logic [10:0] r4_s8;
	logic [22:0] mp_s8;
	logic [8:0]  doy_s9;
	logic        leap_s9, err_s9;
	logic [6:0]  yoff_s9;
	logic [5:0]  min_s9, sec_s9;
	logic [15:0] date_s10, time_s10;
	logic        err_s10;

	// stage 4 correction
	logic [24:0] diff4;
	logic [15:0] days4;
	logic [9:0]  rr4;
	// stage 5 leap fix
	logic [16:0] sum5;
	logic [15:0] dp5;
	// stage 9 year split
	logic [1:0]  yi9;
	logic [8:0]  doy9;
	logic [7:0]  yabs9;
	logic [5:0]  mn9;
	// stage 10 month search
	logic [3:0]  mi10;
	logic [4:0]  md10;

	always_comb begin
		diff4 = t_s3[31:7] - pq_s3[24:0];
		if (diff4[10:0] >= 11'(ecv_pkg::Div675)) begin
			days4 = q_s3 + 16'd1;
			rr4   = 10'(diff4[10:0] - 11'(ecv_pkg::Div675));
		end else begin
			days4 = q_s3;
			rr4   = diff4[9:0];
		end
	end

	always_comb begin
		sum5 = 17'(days_s4) + ecv_pkg::DaysFrom1968;
		if (sum5 >= ecv_pkg::Skip2100)
			dp5 = 16'(sum5 + 17'd1);
		else
			dp5 = sum5[15:0];
	end

	always_comb begin
		if (r4_s8 < 11'd366) begin
			yi9  = 2'd0;
			doy9 = r4_s8[8:0];
		end else if (r4_s8 < 11'd731) begin
			yi9  = 2'd1;
			doy9 = 9'(r4_s8 - 11'd366);
		end else if (r4_s8 < 11'd1096) begin
			yi9  = 2'd2;
			doy9 = 9'(r4_s8 - 11'd731);
		end else begin
			yi9  = 2'd3;
			doy9 = 9'(r4_s8 - 11'd1096);
		end
		yabs9 = {c_s8, 2'b00} + 8'(yi9);
		mn9   = mp_s8[21:16];
	end

	always_comb begin
		mi10 = 4'd0;
		for (int k = 1; k < 12; k++)
			if (doy_s9 >= ecv_pkg::month_start(4'(k), leap_s9))
				mi10 = 4'(k);
		md10 = 5'(doy_s9 - ecv_pkg::month_start(mi10, leap_s9) + 9'd1);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sel_s[1] <= (operation == ecv_pkg::OP_TO_DOS);
			t_s1     <= seconds_in + 32'(zone_offset);
		end
		for (int k = 2; k < ecv_pkg::NumStages; k++)
			if (en[k-1])
				sel_s[k] <= sel_s[k-1];
		if (en[1]) begin
			t_s2 <= t_s1;
			p_s2 <= 51'(t_s1[31:7]) * 51'(ecv_pkg::Rcp675);
		end
		if (en[2]) begin
			t_s3  <= t_s2;
			q_s3  <= p_s2[50:35];
			pq_s3 <= 26'(p_s2[50:35]) * 26'(ecv_pkg::Div675);
		end
		if (en[3]) begin
			days_s4 <= days4;
			rem_s4  <= {rr4, t_s3[6:0]};
		end
		if (en[4]) begin
			dp_s5  <= dp5;
			hp_s5  <= 30'(rem_s4[16:4]) * 30'(ecv_pkg::Rcp225);
			rem_s5 <= rem_s4;
		end
		if (en[5]) begin
			cp_s6   <= 32'(dp_s5) * 32'(ecv_pkg::Rcp1461);
			hour_s6 <= hp_s5[28:24];
			hm_s6   <= 17'(hp_s5[28:24]) * 17'd3600;
			rem_s6  <= rem_s5;
			dp_s6   <= dp_s5;
		end
		if (en[6]) begin
			c_s7    <= cp_s6[31:26];
			cm_s7   <= 16'(cp_s6[31:26]) * 16'(ecv_pkg::Days4Yr);
			rem2_s7 <= 12'(rem_s6 - hm_s6);
			dp_s7   <= dp_s6;
			hour_s7 <= hour_s6;
		end
		if (en[7]) begin
			r4_s8   <= 11'(dp_s7 - cm_s7);
			mp_s8   <= 23'(rem2_s7[11:2]) * 23'(ecv_pkg::Rcp15);
			rem2_s8 <= rem2_s7;
			c_s8    <= c_s7;
			hour_s8 <= hour_s7;
		end
		if (en[8]) begin
			doy_s9  <= doy9;
			leap_s9 <= (yi9 == 2'd0);
			err_s9  <= (yabs9 < 8'd12);
			yoff_s9 <= 7'(yabs9 - 8'd12);
			min_s9  <= mn9;
			sec_s9  <= 6'(rem2_s8 - 12'(mn9) * 12'd60);
			hour_s9 <= hour_s8;
		end
		if (en[9]) begin
			err_s10 <= sel_s[9] && err_s9;
			if (sel_s[9] && !err_s9) begin
				date_s10 <= {yoff_s9, mi10 + 4'd1, md10};
				time_s10 <= {hour_s9, min_s9, sec_s9[5:1]};
			end else begin
				date_s10 <= '0;
				time_s10 <= '0;
			end
		end
	end

	assign dos_date    = date_s10;
	assign dos_time    = time_s10;
	assign range_error = err_s10;

endmodule

@@ src/ecv_secs.sv @@
// Seconds results: packed FAT date and time to epoch seconds, and local shifts.
module ecv_secs (
	input  logic                               clk,
	input  logic [ecv_pkg::NumStages-1:0]      en,
	input  logic [2:0]                         operation,
	input  logic [31:0]                        seconds_in,
	input  logic [15:0]                        dos_date_in,
	input  logic [15:0]                        dos_time_in,
	input  logic signed [17:0]                 zone_offset,
	output logic [31:0]                        seconds,
	output logic                               range_error
);

	localparam int unsigned FirstPad = 4;

	function automatic logic [15:0] year_start(input logic [6:0] y);
		logic [15:0] d;
		d = 16'd3652 + 16'(y) * 16'd365 + 16'((8'(y) + 8'd3) >> 2);
		if (y > 7'd120)
			d = d - 16'd1;
		return d;
	endfunction

	logic [6:0]  y1;
	logic [3:0]  mon1;
	logic        leap1;

	logic        dos_s1, dos_s2, dos_s3;
	logic        loc_s1, loc_s2, loc_s3;
	logic        bad_s1, bad_s2, bad_s3;
	logic [31:0] lt_s1, lt_s2, lt_s3;
	logic [15:0] ys_s1;
	logic [8:0]  ms_s1;
	logic [4:0]  md_s1, ss_s1;
	logic [16:0] hs_s1;
	logic [11:0] mm_s1;
	logic [15:0] days_s2;
	logic [16:0] tp_s2, tp_s3;
	logic [31:0] ds_s3;

	logic [31:0] res_s [FirstPad:ecv_pkg::NumStages];
	logic        err_s [FirstPad:ecv_pkg::NumStages];

	assign y1    = dos_date_in[15:9];
	assign mon1  = dos_date_in[8:5];
	assign leap1 = (y1[1:0] == 2'b00) && (y1 != 7'd120);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dos_s1 <= (operation == ecv_pkg::OP_FROM_DOS);
			loc_s1 <= (operation == ecv_pkg::OP_TO_LOCAL) ||
			          (operation == ecv_pkg::OP_FROM_LOCAL);
			lt_s1  <= (operation == ecv_pkg::OP_TO_LOCAL) ?
			          seconds_in + 32'(zone_offset) : seconds_in - 32'(zone_offset);
			bad_s1 <= (mon1 == 4'd0) || (mon1 > 4'd12);
			ys_s1  <= year_start(y1);
			ms_s1  <= ecv_pkg::month_start(mon1 - 4'd1, leap1);
			md_s1  <= dos_date_in[4:0];
			hs_s1  <= 17'(dos_time_in[15:11]) * 17'd3600;
			mm_s1  <= 12'(dos_time_in[10:5]) * 12'd60;
			ss_s1  <= dos_time_in[4:0];
		end
		if (en[1]) begin
			dos_s2  <= dos_s1;
			loc_s2  <= loc_s1;
			lt_s2   <= lt_s1;
			bad_s2  <= bad_s1;
			days_s2 <= ys_s1 + 16'(ms_s1) + 16'(md_s1) - 16'd1;
			tp_s2   <= hs_s1 + 17'(mm_s1) + 17'({ss_s1, 1'b0});
		end
		if (en[2]) begin
			dos_s3 <= dos_s2;
			loc_s3 <= loc_s2;
			lt_s3  <= lt_s2;
			bad_s3 <= bad_s2;
			tp_s3  <= tp_s2;
			ds_s3  <= 32'(days_s2) * 32'd86400;
		end
		if (en[FirstPad-1]) begin
			err_s[FirstPad] <= dos_s3 && bad_s3;
			if (dos_s3 && !bad_s3)
				res_s[FirstPad] <= ds_s3 + 32'(tp_s3) - 32'(zone_offset);
			else if (loc_s3)
				res_s[FirstPad] <= lt_s3;
			else
				res_s[FirstPad] <= '0;
		end
		for (int k = FirstPad + 1; k <= ecv_pkg::NumStages; k++)
			if (en[k-1]) begin
				res_s[k] <= res_s[k-1];
				err_s[k] <= err_s[k-1];
			end
	end

	assign seconds     = res_s[ecv_pkg::NumStages];
	assign range_error = err_s[ecv_pkg::NumStages];

endmodule

@@ src/ecv_nt.sv @@
// NT file time conversions: scaled multiply one way, reciprocal multiply the other.
module ecv_nt (
	input  logic                               clk,
	input  logic [ecv_pkg::NumStages-1:0]      en,
	input  logic [2:0]                         operation,
	input  logic [31:0]                        seconds_in,
	input  logic signed [63:0]                 nt_time_in,
	output logic [57:0]                        nt_time,
	output logic [31:0]                        seconds
);

	localparam int unsigned QFirst = 4;
	localparam int unsigned QLast  = 8;
	localparam int unsigned NtDone = 3;

	logic [63:0] mag1;
	logic [76:0] acc4;

	logic        to_s [1:ecv_pkg::NumStages];
	logic        fr_s [1:ecv_pkg::NumStages];
	logic        neg_s [1:QLast];
	logic [34:0] a_s1;
	logic [56:0] x_s1;
	logic [40:0] pl_s2;
	logic [41:0] ph_s2;
	logic [57:0] rll_s2, rlh_s2, rhl_s2, rhh_s2;
	logic [59:0] rmid_s3;
	logic [57:0] rhh_s3;
	logic [57:0] nt_s [NtDone:ecv_pkg::NumStages];
	logic [31:0] q_s [QFirst:QLast];
	logic [31:0] q_s9;
	logic [31:0] sec_s10;

	assign mag1 = nt_time_in[63] ? 64'(-nt_time_in) : 64'(nt_time_in);

	// low 29 bits of the low partial product never carry; only quotient bits 31:0 kept
	assign acc4 = {rhh_s3[47:0], 29'd0} + 77'(rmid_s3);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			to_s[1]  <= (operation == ecv_pkg::OP_TO_NT);
			fr_s[1]  <= (operation == ecv_pkg::OP_FROM_NT);
			neg_s[1] <= nt_time_in[63];
			a_s1     <= 35'(seconds_in) + 35'(ecv_pkg::NtEpochGap);
			x_s1     <= mag1[63:7];
		end
		for (int k = 2; k <= ecv_pkg::NumStages; k++)
			if (en[k-1]) begin
				to_s[k] <= to_s[k-1];
				fr_s[k] <= fr_s[k-1];
			end
		for (int k = 2; k <= QLast; k++)
			if (en[k-1])
				neg_s[k] <= neg_s[k-1];
		if (en[1]) begin
			pl_s2  <= 41'(a_s1[16:0]) * 41'(ecv_pkg::NtTicks);
			ph_s2  <= 42'(a_s1[34:17]) * 42'(ecv_pkg::NtTicks);
			rll_s2 <= 58'(x_s1[28:0]) * 58'(ecv_pkg::NtRcpLo);
			rlh_s2 <= 58'(x_s1[28:0]) * 58'(ecv_pkg::NtRcpHi);
			rhl_s2 <= 58'(x_s1[56:29]) * 58'(ecv_pkg::NtRcpLo);
			rhh_s2 <= 58'(x_s1[56:29]) * 58'(ecv_pkg::NtRcpHi);
		end
		if (en[2]) begin
			rmid_s3 <= 60'(rlh_s2) + 60'(rhl_s2) + 60'(rll_s2[57:29]);
			rhh_s3  <= rhh_s2;
		end
		if (en[3])
			q_s[QFirst] <= acc4[76:45];
		for (int k = QFirst + 1; k <= QLast; k++)
			if (en[k-1])
				q_s[k] <= q_s[k-1];
		if (en[NtDone-1])
			nt_s[NtDone] <= 58'(59'(pl_s2) + {ph_s2, 17'd0});
		for (int k = NtDone + 1; k <= ecv_pkg::NumStages; k++)
			if (en[k-1])
				nt_s[k] <= nt_s[k-1];
		if (en[QLast])
			q_s9 <= neg_s[QLast] ? (32'd0 - q_s[QLast]) : q_s[QLast];
		if (en[QLast+1])
			sec_s10 <= q_s9 - 32'(ecv_pkg::NtEpochGap);
	end

	assign nt_time = to_s[ecv_pkg::NumStages] ? nt_s[ecv_pkg::NumStages] : '0;
	assign seconds = fr_s[ecv_pkg::NumStages] ? sec_s10 : '0;

endmodule

@@ src/ecv_chk.sv @@
// Port-level checker for the time converter, bound to the top level.
module ecv_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input ecv_pkg::out_t        out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output not blocked");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.range_error |->
			out_data.seconds_out == '0 && out_data.dos_date_out == '0 &&
			out_data.dos_time_out == '0 && out_data.nt_time_out == '0)
		else $error("range error with nonzero fields");

	a_nt_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.nt_time_out != '0 |->
			out_data.seconds_out == '0 && out_data.dos_date_out == '0 &&
			out_data.dos_time_out == '0 && !out_data.range_error)
		else $error("NT result mixed with other fields");

endmodule

bind epoch_dos_nt_time_converter ecv_chk u_ecv_chk (.*);
